[src/lae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lae_pkg;

	// Fixed-point constants (logs are signed Q.12 in 20 bits, core math in Q30)
	localparam logic [31:0]        ONE_Q30       = 32'h4000_0000;
	localparam logic [31:0]        LN2_Q30       = 32'd744261118;
	localparam logic signed [19:0] LOG_FLOOR_Q12 = -20'sd37726;
	localparam logic signed [19:0] LOG_MIN_Q12   = -20'sd524288;
	localparam logic signed [19:0] LOG_MAX_Q12   = 20'sd524287;
	localparam logic [23:0]        U24_MAX       = 24'hFF_FFFF;

	localparam int GRID_SIDE_DEF = 64;

	// Frame-end queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Register reset values
	localparam logic [23:0] TARGET_RST = 24'd11796;
	localparam logic [23:0] MIN_RST    = 24'd6554;
	localparam logic [23:0] MAX_RST    = 24'd655360;
	localparam logic [15:0] DARK_RST   = 16'd12288;
	localparam logic [15:0] BRIGHT_RST = 16'd4096;

	typedef enum logic [2:0] {
		REG_TARGET = 3'd0,
		REG_MIN    = 3'd1,
		REG_MAX    = 3'd2,
		REG_DARK   = 3'd3,
		REG_BRIGHT = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		OP_SAMPLE    = 1'b0,
		OP_FRAME_END = 1'b1
	} opcode_t;

	// One closed frame handed from front to back
	typedef struct packed {
		logic [19:0]        dt;
		logic [23:0]        cur;
		logic signed [31:0] sum;
		logic               seen;
	} lae_job_t;

	typedef struct packed {
		logic [23:0] target;
		logic [23:0] min_exp;
		logic [23:0] max_exp;
		logic [15:0] rate_dark;
		logic [15:0] rate_bright;
	} lae_cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EXP_START,
		ST_EXP_RED,
		ST_EXP_QR,
		ST_EXP_MUL,
		ST_EXP_ACC,
		ST_EXP_END,
		ST_LN_START,
		ST_LN_SQ,
		ST_LN_MUL,
		ST_LN_ACC,
		ST_LN_END,
		ST_DES,
		ST_RATE,
		ST_SMUL,
		ST_SFIN,
		ST_OUT,
		ST_DIV_WAIT
	} bk_state_t;

	typedef enum logic [2:0] {
		JOB_MEAN,
		JOB_LNT,
		JOB_LNMIN,
		JOB_LNMAX,
		JOB_LNCUR,
		JOB_SMOOTH,
		JOB_NEW
	} bk_job_t;

endpackage

`default_nettype wire

[src/log_average_auto_exposure.sv]
// Auto-exposure from a stream of log-luminance samples.
// Input stream (s_axis): tuser 0 = sample, tdata[15:0] is a binary16 log-luminance
// value; tuser 1 = frame end, tdata carries the time step and current exposure.
// Samples are taken one per cycle while the queue is not full and produce no
// result. Each frame end produces one result on m_axis: the new exposure, the
// mean luminance, and tuser = 1 when the frame had no samples (current exposure
// passed through). The front end sums samples and queues closed frames in a
// 4-deep queue; the back end works each frame through exp/ln series: exp range
// reduction is a 9-step compare and subtract, series divisions by small
// constants are reciprocal multiplies, and each ln uses a restoring divider.
// s_axis_tready drops only while the queue is full. The result sits in an output
// register, so a stalled receiver holds the back end at most, never the sample
// stream until the queue fills.
// Reset clears the sum, the smoothing state and the queue, and loads register
// defaults. Configuration (cfg_wr_en/cfg_index/cfg_data) is to be written only
// while idle; the user is bound to this, and the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module log_average_auto_exposure #(
	parameter int GRID_SIDE = lae_pkg::GRID_SIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] sample_half, [35:16] elapsed_time, [59:36] current_exposure
	input  wire logic [63:0] s_axis_tdata,
	// [0] opcode
	input  wire logic        s_axis_tuser,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [23:0] new_exposure, [47:24] mean_luminance
	output logic [47:0]      m_axis_tdata,
	// [0] held
	output logic             m_axis_tuser
);
	import lae_pkg::*;

	lae_cfg_t    cfg_q;
	lae_job_t    push_job;
	lae_job_t    pop_job;
	logic        q_push;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;
	logic [23:0] res_new;
	logic [23:0] res_mean;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target      <= TARGET_RST;
			cfg_q.min_exp     <= MIN_RST;
			cfg_q.max_exp     <= MAX_RST;
			cfg_q.rate_dark   <= DARK_RST;
			cfg_q.rate_bright <= BRIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				REG_TARGET: cfg_q.target      <= cfg_data;
				REG_MIN:    cfg_q.min_exp     <= cfg_data;
				REG_MAX:    cfg_q.max_exp     <= cfg_data;
				REG_DARK:   cfg_q.rate_dark   <= cfg_data[15:0];
				REG_BRIGHT: cfg_q.rate_bright <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	lae_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_data  (s_axis_tdata),
		.s_kind  (s_axis_tuser),
		.q_push  (q_push),
		.q_din   (push_job),
		.q_full  (q_full)
	);

	lae_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_job),
		.full   (q_full),
		.valid  (q_valid),
		.dout   (pop_job),
		.pop    (q_pop)
	);

	lae_back #(
		.GRID_SIDE (GRID_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (pop_job),
		.q_pop     (q_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_new   (res_new),
		.res_mean  (res_mean),
		.res_held  (m_axis_tuser)
	);

	assign m_axis_tdata = {res_mean, res_new};

endmodule

`default_nettype wire

[src/lae_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module lae_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] rem2;
	logic        qbit;
	logic [31:0] rem_n;

	// trial subtract
	always_comb begin
		rem2  = {rem_q, quo_q[63]};
		qbit  = (rem2 >= {1'b0, dvs_q});
		rem_n = qbit ? 32'(rem2 - {1'b0, dvs_q}) : rem2[31:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[62:0], qbit};
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[src/lae_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Takes items, decodes and sums samples, queues closed frames
module lae_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_valid,
	output logic                  s_ready,
	input  wire logic [63:0]      s_data,
	input  wire logic             s_kind,
	output logic                  q_push,
	output lae_pkg::lae_job_t     q_din,
	input  wire logic             q_full
);
	import lae_pkg::*;

	logic signed [31:0] sum_q;
	logic               seen_q;
	logic               accept;
	logic signed [20:0] dec;
	logic signed [32:0] sum33;
	logic signed [31:0] sum_sat;

	// binary16 to Q.12, rounded half up, magnitude saturated
	function automatic logic signed [20:0] decode_half(input logic [15:0] h);
		logic [4:0]  ex;
		logic [4:0]  ee;
		logic [10:0] m;
		logic [27:0] big;
		logic [18:0] mag;
		ex  = h[14:10];
		m   = (ex != 5'd0) ? {1'b1, h[9:0]} : {1'b0, h[9:0]};
		ee  = (ex != 5'd0) ? ex : 5'd1;
		big = '0;
		if (ex == 5'h1F) begin
			mag = LOG_MAX_Q12[18:0];
		end else if (h[14:0] == 15'd0) begin
			mag = '0;
		end else if (ee >= 5'd13) begin
			big = 28'(m) << (ee - 5'd13);
			mag = (big > 28'(LOG_MAX_Q12)) ? LOG_MAX_Q12[18:0] : big[18:0];
		end else begin
			big = (28'(m) + (28'd1 << (5'd12 - ee))) >> (5'd13 - ee);
			mag = big[18:0];
		end
		return h[15] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
	endfunction

	assign s_ready = !q_full;
	assign accept  = s_valid && !q_full;

	// saturating accumulate
	always_comb begin
		dec   = decode_half(s_data[15:0]);
		sum33 = 33'(sum_q) + 33'(dec);
		if (sum33 > 33'sd2147483647)
			sum_sat = 32'sh7FFF_FFFF;
		else if (sum33 < -33'sd2147483648)
			sum_sat = 32'sh8000_0000;
		else
			sum_sat = sum33[31:0];
	end

	// a frame end hands the frame to the back end and starts a new one
	assign q_push    = accept && (opcode_t'(s_kind) == OP_FRAME_END);
	assign q_din.dt  = s_data[35:16];
	assign q_din.cur = s_data[59:36];
	assign q_din.sum = sum_q;
	assign q_din.seen = seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			if (opcode_t'(s_kind) == OP_FRAME_END) begin
				sum_q  <= '0;
				seen_q <= 1'b0;
			end else begin
				sum_q  <= sum_sat;
				seen_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[src/lae_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

// Short queue of closed frames
module lae_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lae_pkg::lae_job_t din,
	output logic                   full,
	output logic                   valid,
	output lae_pkg::lae_job_t      dout,
	input  wire logic              pop
);
	import lae_pkg::*;

	lae_job_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

endmodule

`default_nettype wire

[src/lae_back.sv]
`timescale 1ns / 1ps
`default_nettype none

// Frame-end sequencer: exp/ln series with a shared divider for the ln steps
module lae_back #(
	parameter int GRID_SIDE = lae_pkg::GRID_SIDE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lae_pkg::lae_cfg_t cfg,
	input  wire logic              q_valid,
	input  wire lae_pkg::lae_job_t q_data,
	output logic                   q_pop,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic [23:0]            res_new,
	output logic [23:0]            res_mean,
	output logic                   res_held
);
	import lae_pkg::*;

	localparam int AVG_SHIFT = $clog2(GRID_SIDE * GRID_SIDE + 1) - 1;

	bk_state_t          state_q, state_d, ret_q, ret_d;
	bk_job_t            job_q, job_d;
	lae_job_t           ent_q, ent_d;
	logic signed [39:0] x_q, x_d;
	logic signed [11:0] n_q, n_d;
	logic [29:0]        rem_q, rem_d;
	logic [31:0]        p_q, p_d;
	logic [3:0]         k_q, k_d;
	logic [39:0]        rr_q, rr_d;
	logic [8:0]         qq_q, qq_d;
	logic [30:0]        hq_q, hq_d;
	logic [23:0]        xln_q, xln_d;
	logic [4:0]         e_q, e_d;
	logic               lnzero_q, lnzero_d;
	logic [29:0]        z2_q, z2_d;
	logic [29:0]        term_q, term_d;
	logic [30:0]        acc_q, acc_d;
	logic [23:0]        mean_q, mean_d;
	logic [23:0]        new_q, new_d;
	logic signed [19:0] avg_q, avg_d;
	logic signed [19:0] lnt_q, lnt_d, lnmin_q, lnmin_d, lnmax_q, lnmax_d;
	logic signed [19:0] curlog_q, curlog_d, d_q, d_d, sm_q, sm_d;
	logic [30:0]        om_q, om_d;
	logic signed [52:0] prod_q, prod_d;
	logic               started_q, started_d;
	logic               res_valid_q, res_valid_d;
	logic [23:0]        res_new_q, res_new_d, res_mean_q, res_mean_d;
	logic               res_held_q, res_held_d;

	logic               div_start;
	logic [63:0]        div_dvd;
	logic [31:0]        div_dvs;
	logic               div_done;
	logic [63:0]        div_quo;

	// combinational temporaries
	logic [39:0]        xmag;
	logic [39:0]        lnsh;
	logic [61:0]        pr;
	logic [59:0]        zz;
	logic [4:0]         msb;
	logic [63:0]        m64;
	logic [30:0]        m31;
	logic signed [5:0]  e6;
	logic signed [39:0] ln_all;
	logic signed [39:0] ln_rnd;
	logic signed [19:0] lnv;
	logic signed [31:0] sum_sh;
	logic signed [19:0] fl;
	logic signed [21:0] dd;
	logic [15:0]        rate;
	logic [35:0]        tt;
	logic [31:0]        e30;
	logic signed [20:0] diff;
	logic signed [52:0] rs;
	logic signed [19:0] s_new;

	lae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	function automatic logic signed [19:0] clamp20(input logic signed [39:0] v);
		if (v < 40'(LOG_MIN_Q12))
			return LOG_MIN_Q12;
		if (v > 40'(LOG_MAX_Q12))
			return LOG_MAX_Q12;
		return v[19:0];
	endfunction

	// floor(x / k) for x < 2^31 and k in 1..15, by reciprocal multiply
	function automatic logic [30:0] div_small(input logic [30:0] x, input logic [3:0] k);
		logic [31:0] m;
		logic [5:0]  sh;
		logic [62:0] prd;
		case (k)
			4'd1:    begin m = 32'd2147483648; sh = 6'd31; end
			4'd2:    begin m = 32'd2147483648; sh = 6'd32; end
			4'd3:    begin m = 32'd2863311531; sh = 6'd33; end
			4'd4:    begin m = 32'd2147483648; sh = 6'd33; end
			4'd5:    begin m = 32'd3435973837; sh = 6'd34; end
			4'd6:    begin m = 32'd2863311531; sh = 6'd34; end
			4'd7:    begin m = 32'd2454267027; sh = 6'd34; end
			4'd8:    begin m = 32'd2147483648; sh = 6'd34; end
			4'd9:    begin m = 32'd3817748708; sh = 6'd35; end
			4'd10:   begin m = 32'd3435973837; sh = 6'd35; end
			4'd11:   begin m = 32'd3123612579; sh = 6'd35; end
			4'd12:   begin m = 32'd2863311531; sh = 6'd35; end
			4'd13:   begin m = 32'd2643056798; sh = 6'd35; end
			4'd14:   begin m = 32'd2454267027; sh = 6'd35; end
			4'd15:   begin m = 32'd2290649225; sh = 6'd35; end
			default: begin m = 32'd0;          sh = 6'd31; end
		endcase
		prd = 63'(x) * 63'(m);
		return 31'(prd >> sh);
	endfunction

	// 2^n * p (p in Q30) to Q8.16, rounded half up, saturated
	function automatic logic [23:0] to_q16(input logic [31:0] p, input logic signed [11:0] n);
		logic signed [12:0] sh;
		logic [63:0]        v;
		sh = 13'sd14 - 13'(n);
		v  = '0;
		if (n >= 12'sd8)
			return U24_MAX;
		if (sh >= 13'sd62)
			return 24'd0;
		v = (64'(p) + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
		return (v > 64'(U24_MAX)) ? U24_MAX : v[23:0];
	endfunction

	// next state and datapath
	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		job_d       = job_q;
		ent_d       = ent_q;
		x_d         = x_q;
		n_d         = n_q;
		rem_d       = rem_q;
		p_d         = p_q;
		k_d         = k_q;
		rr_d        = rr_q;
		qq_d        = qq_q;
		hq_d        = hq_q;
		xln_d       = xln_q;
		e_d         = e_q;
		lnzero_d    = lnzero_q;
		z2_d        = z2_q;
		term_d      = term_q;
		acc_d       = acc_q;
		mean_d      = mean_q;
		new_d       = new_q;
		avg_d       = avg_q;
		lnt_d       = lnt_q;
		lnmin_d     = lnmin_q;
		lnmax_d     = lnmax_q;
		curlog_d    = curlog_q;
		d_d         = d_q;
		sm_d        = sm_q;
		om_d        = om_q;
		prod_d      = prod_q;
		started_d   = started_q;
		res_valid_d = res_valid_q;
		res_new_d   = res_new_q;
		res_mean_d  = res_mean_q;
		res_held_d  = res_held_q;
		q_pop       = 1'b0;
		div_start   = 1'b0;
		div_dvd     = '0;
		div_dvs     = '0;

		// output register drains on its own
		if (res_valid_q && res_ready)
			res_valid_d = 1'b0;

		xmag   = x_q[39] ? 40'(-x_q) : 40'(x_q);
		lnsh   = 40'(LN2_Q30) << k_q;
		pr     = 62'(p_q) * 62'(rem_q);
		zz     = 60'(term_q) * 60'(z2_q);
		msb    = '0;
		for (int i = 0; i < 24; i++)
			if (xln_q[i])
				msb = 5'(i);
		m64    = 64'(xln_q) << (6'd30 - 6'(msb));
		m31    = m64[30:0];
		e6     = $signed({1'b0, e_q}) - 6'sd16;
		ln_all = 40'(e6) * $signed({8'b0, LN2_Q30}) + $signed({8'b0, acc_q, 1'b0});
		ln_rnd = (ln_all + 40'sd131072) >>> 18;
		lnv    = lnzero_q ? LOG_MIN_Q12 : clamp20(ln_rnd);
		sum_sh = ent_q.sum >>> AVG_SHIFT;
		fl     = (avg_q > LOG_FLOOR_Q12) ? avg_q : LOG_FLOOR_Q12;
		dd     = 22'(lnt_q) - 22'(fl);
		rate   = (d_q < sm_q) ? cfg.rate_dark : cfg.rate_bright;
		tt     = 36'(rate) * 36'(ent_q.dt);
		e30    = (n_q <= -12'sd31) ? 32'd0 : (p_q >> 5'(-n_q));
		diff   = 21'(d_q) - 21'(curlog_q);
		rs     = (prod_q + 53'sd536870912) >>> 30;
		s_new  = clamp20(40'(curlog_q) + 40'(rs));

		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					ent_d   = q_data;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!ent_q.seen) begin
					state_d = ST_OUT;
				end else begin
					avg_d   = clamp20(40'(sum_sh));
					x_d     = 40'(clamp20(40'(sum_sh))) <<< 18;
					job_d   = JOB_MEAN;
					state_d = ST_EXP_START;
				end
			end
			// exp: split off the multiple of ln2 (quotient below 512)
			ST_EXP_START: begin
				rr_d    = xmag;
				qq_d    = '0;
				k_d     = 4'd8;
				state_d = ST_EXP_RED;
			end
			ST_EXP_RED: begin
				if (rr_q >= lnsh) begin
					rr_d = rr_q - lnsh;
					qq_d = qq_q | (9'd1 << k_q);
				end
				if (k_q == 4'd0)
					state_d = ST_EXP_QR;
				else
					k_d = k_q - 4'd1;
			end
			ST_EXP_QR: begin
				if (!x_q[39]) begin
					n_d   = $signed({3'b000, qq_q});
					rem_d = rr_q[29:0];
				end else if (rr_q == '0) begin
					n_d   = -$signed({3'b000, qq_q});
					rem_d = '0;
				end else begin
					n_d   = -$signed({3'b000, qq_q}) - 12'sd1;
					rem_d = 30'(LN2_Q30 - 32'(rr_q[29:0]));
				end
				p_d     = ONE_Q30;
				k_d     = 4'd12;
				state_d = ST_EXP_MUL;
			end
			// Horner step: p = 1 + (p*r)/k
			ST_EXP_MUL: begin
				hq_d    = pr[60:30];
				state_d = ST_EXP_ACC;
			end
			ST_EXP_ACC: begin
				p_d = ONE_Q30 + 32'(div_small(hq_q, k_q));
				if (k_q == 4'd1) begin
					state_d = ST_EXP_END;
				end else begin
					k_d     = k_q - 4'd1;
					state_d = ST_EXP_MUL;
				end
			end
			ST_EXP_END: begin
				case (job_q)
					JOB_MEAN: begin
						mean_d  = to_q16(p_q, n_q);
						job_d   = JOB_LNT;
						xln_d   = cfg.target;
						state_d = ST_LN_START;
					end
					JOB_SMOOTH: begin
						om_d    = 31'(ONE_Q30 - e30);
						state_d = ST_SMUL;
					end
					default: begin
						new_d   = to_q16(p_q, n_q);
						state_d = ST_OUT;
					end
				endcase
			end
			// ln: normalize, then z = (m-1)/(m+1)
			ST_LN_START: begin
				if (xln_q == '0) begin
					lnzero_d = 1'b1;
					state_d  = ST_LN_END;
				end else begin
					lnzero_d  = 1'b0;
					e_d       = msb;
					div_start = 1'b1;
					div_dvd   = (64'(m31) - 64'(ONE_Q30)) << 30;
					div_dvs   = 32'(m31) + ONE_Q30;
					ret_d     = ST_LN_SQ;
					state_d   = ST_DIV_WAIT;
				end
			end
			ST_LN_SQ: begin
				z2_d    = 30'((60'(div_quo[29:0]) * 60'(div_quo[29:0])) >> 30);
				term_d  = div_quo[29:0];
				acc_d   = 31'(div_quo[29:0]);
				k_d     = 4'd3;
				state_d = ST_LN_MUL;
			end
			// odd series term: term *= z^2, acc += term/k
			ST_LN_MUL: begin
				term_d  = zz[59:30];
				state_d = ST_LN_ACC;
			end
			ST_LN_ACC: begin
				acc_d = acc_q + div_small({1'b0, term_q}, k_q);
				if (k_q == 4'd15) begin
					state_d = ST_LN_END;
				end else begin
					k_d     = k_q + 4'd2;
					state_d = ST_LN_MUL;
				end
			end
			ST_LN_END: begin
				case (job_q)
					JOB_LNT: begin
						lnt_d   = lnv;
						job_d   = JOB_LNMIN;
						xln_d   = cfg.min_exp;
						state_d = ST_LN_START;
					end
					JOB_LNMIN: begin
						lnmin_d = lnv;
						job_d   = JOB_LNMAX;
						xln_d   = cfg.max_exp;
						state_d = ST_LN_START;
					end
					JOB_LNMAX: begin
						lnmax_d = lnv;
						job_d   = JOB_LNCUR;
						xln_d   = ent_q.cur;
						state_d = ST_LN_START;
					end
					default: begin
						curlog_d = (lnv < LOG_FLOOR_Q12) ? LOG_FLOOR_Q12 : lnv;
						state_d  = ST_DES;
					end
				endcase
			end
			// desired log exposure, clamped to the register limits (max wins)
			ST_DES: begin
				if (dd < 22'(lnmin_q))
					dd = 22'(lnmin_q);
				if (dd > 22'(lnmax_q))
					dd = 22'(lnmax_q);
				d_d     = dd[19:0];
				state_d = ST_RATE;
			end
			ST_RATE: begin
				if (!started_q) begin
					sm_d      = d_q;
					started_d = 1'b1;
					x_d       = 40'(d_q) <<< 18;
					job_d     = JOB_NEW;
				end else begin
					x_d   = -$signed({2'b00, tt, 2'b00});
					job_d = JOB_SMOOTH;
				end
				state_d = ST_EXP_START;
			end
			ST_SMUL: begin
				prod_d  = 53'(diff) * 53'($signed({1'b0, om_q}));
				state_d = ST_SFIN;
			end
			ST_SFIN: begin
				sm_d    = s_new;
				x_d     = 40'(s_new) <<< 18;
				job_d   = JOB_NEW;
				state_d = ST_EXP_START;
			end
			ST_OUT: begin
				if (!res_valid_q || res_ready) begin
					res_valid_d = 1'b1;
					res_held_d  = !ent_q.seen;
					res_new_d   = ent_q.seen ? new_q : ent_q.cur;
					res_mean_d  = ent_q.seen ? mean_q : 24'd0;
					state_d     = ST_IDLE;
				end
			end
			ST_DIV_WAIT: begin
				if (div_done)
					state_d = ret_q;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			job_q       <= JOB_MEAN;
			started_q   <= 1'b0;
			sm_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			job_q       <= job_d;
			started_q   <= started_d;
			sm_q        <= sm_d;
			res_valid_q <= res_valid_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		ent_q      <= ent_d;
		x_q        <= x_d;
		n_q        <= n_d;
		rem_q      <= rem_d;
		p_q        <= p_d;
		k_q        <= k_d;
		rr_q       <= rr_d;
		qq_q       <= qq_d;
		hq_q       <= hq_d;
		xln_q      <= xln_d;
		e_q        <= e_d;
		lnzero_q   <= lnzero_d;
		z2_q       <= z2_d;
		term_q     <= term_d;
		acc_q      <= acc_d;
		mean_q     <= mean_d;
		new_q      <= new_d;
		avg_q      <= avg_d;
		lnt_q      <= lnt_d;
		lnmin_q    <= lnmin_d;
		lnmax_q    <= lnmax_d;
		curlog_q   <= curlog_d;
		d_q        <= d_d;
		om_q       <= om_d;
		prod_q     <= prod_d;
		res_new_q  <= res_new_d;
		res_mean_q <= res_mean_d;
		res_held_q <= res_held_d;
	end

	assign res_valid = res_valid_q;
	assign res_new   = res_new_q;
	assign res_mean  = res_mean_q;
	assign res_held  = res_held_q;

endmodule

`default_nettype wire
